// File: rtl/vfdmr_pkg.sv
// package for the display multiplexer: op codes, register indexes, glyph tables
// no dependencies
`timescale 1ns / 1ps

package vfdmr_pkg;

  localparam int unsigned DigitCount = 6;
  localparam int unsigned GateCount  = DigitCount / 2;
  localparam int unsigned GlyphCodes = 32;

  localparam int unsigned OpW        = 2;
  localparam int unsigned CodeW      = 5;
  localparam int unsigned GlyphW     = 8;
  localparam int unsigned PeriodW    = 17;
  localparam int unsigned HalfW      = 15;
  localparam int unsigned BlinkW     = 16;
  localparam int unsigned RefreshW   = 8;
  localparam int unsigned WordW      = 19;
  localparam int unsigned GateW      = 2;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 8;

  localparam int unsigned GateBitBase = 16;
  localparam int unsigned DotLowerBit = 7;
  localparam int unsigned DotUpperBit = 15;

  localparam logic [RefreshW-1:0] RefreshReset = 8'd5;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MAP_SELECT = 1'd0,
    CFG_REFRESH_MS = 1'd1
  } cfg_index_e;

  typedef logic [GateW-1:0] gate_t;

  localparam logic [GlyphW-1:0] GLYPH_MAP_A [GlyphCodes] = '{
    8'h7B, 8'h30, 8'h5D, 8'h7C, 8'h36, 8'h6E, 8'h6F, 8'h38,
    8'h7F, 8'h7E, 8'h3F, 8'h67, 8'h4B, 8'h75, 8'h4F, 8'h0F,
    8'h00, 8'h36, 8'h5D, 8'h25, 8'h20, 8'h67, 8'h67, 8'h30,
    8'h4F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [GlyphW-1:0] GLYPH_MAP_B [GlyphCodes] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25,
    8'h7F, 8'h6F, 8'h3F, 8'h7A, 8'h53, 8'h7C, 8'h5B, 8'h1B,
    8'h00, 8'h2E, 8'h5D, 8'h38, 8'h20, 8'h7A, 8'h7A, 8'h24,
    8'h5B, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [GlyphW-1:0] glyph(input logic sel, input logic [CodeW-1:0] code);
    glyph = sel ? GLYPH_MAP_B[code] : GLYPH_MAP_A[code];
  endfunction

endpackage

// File: rtl/vfd_mux_refresh_with_dot_blink.sv
// top level of the display multiplexer with blinking separator dots
// depends on vfdmr_pkg
`timescale 1ns / 1ps

// Takes one word per clock cycle on the input channel; a refresh tick while
// refresh runs yields one driver word in the following cycle, held in the output
// register until taken. The input stalls only while that register holds a
// word that the output side stalls. Blink timing, gate advance and glyph
// lookup all finish in the cycle of acceptance. Configuration writes are
// taken every cycle.
module vfd_mux_refresh_with_dot_blink
  import vfdmr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIndexW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OpW-1:0]             op_i,
  input  logic [CodeW-1:0]           digit0_i,
  input  logic [CodeW-1:0]           digit1_i,
  input  logic [CodeW-1:0]           digit2_i,
  input  logic [CodeW-1:0]           digit3_i,
  input  logic [CodeW-1:0]           digit4_i,
  input  logic [CodeW-1:0]           digit5_i,
  input  logic signed [PeriodW-1:0]  blink_period_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [WordW-1:0]           driver_word_o,
  output logic [GateW-1:0]           gate_index_o
);

  logic                 map_sel_q;
  logic [RefreshW-1:0]  refresh_q;

  logic [CodeW-1:0]     upper_q [GateCount];
  logic [CodeW-1:0]     lower_q [GateCount];

  logic                 hp_neg_q,    hp_neg_d;
  logic [HalfW-1:0]     hp_q,        hp_d;
  logic [BlinkW-1:0]    blink_q,     blink_d;
  logic                 dot_on_q,    dot_on_d;
  gate_t                gate_q,      gate_d;
  logic                 resync_q,    resync_d;
  logic                 stop_q,      stop_d;
  logic                 running_q,   running_d;
  logic                 out_valid_q, out_valid_d;
  logic [WordW-1:0]     word_q,      word_d;
  gate_t                gidx_q;

  logic                 accept;
  logic                 emit;
  logic                 store_en;
  op_e                  op;
  gate_t                g;
  logic [BlinkW-1:0]    blink_base;
  logic [BlinkW:0]      blink_sum;
  logic [BlinkW-1:0]    hp_ext;
  logic                 dot_now;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign op          = op_e'(op_i);

  assign out_valid_o   = out_valid_q;
  assign driver_word_o = word_q;
  assign gate_index_o  = gidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel_q <= 1'b0;
      refresh_q <= RefreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MAP_SELECT: map_sel_q <= cfg_data_i[0];
        CFG_REFRESH_MS: refresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hp_neg_d    = hp_neg_q;
    hp_d        = hp_q;
    blink_d     = blink_q;
    dot_on_d    = dot_on_q;
    gate_d      = gate_q;
    resync_d    = resync_q;
    stop_d      = stop_q;
    running_d   = running_q;
    emit        = 1'b0;
    store_en    = 1'b0;
    g           = (gate_q > gate_t'(GateCount - 1)) ? '0 : gate_q;
    hp_ext      = {{(BlinkW - HalfW){1'b0}}, hp_q};
    blink_base  = resync_q ? hp_ext : blink_q;
    blink_sum   = {1'b0, blink_base} + {{(BlinkW + 1 - RefreshW){1'b0}}, refresh_q};
    dot_now     = dot_on_q;
    if (accept) begin
      case (op)
        OP_UPDATE: begin
          store_en  = 1'b1;
          hp_neg_d  = blink_period_ms_i[PeriodW-1];
          hp_d      = blink_period_ms_i[HalfW:1];
          resync_d  = 1'b1;
          running_d = 1'b1;
        end
        OP_STOP: begin
          stop_d    = 1'b1;
          running_d = 1'b0;
        end
        OP_TICK: begin
          if (stop_q) begin
            stop_d    = 1'b0;
            running_d = 1'b0;
          end else if (running_q) begin
            emit = 1'b1;
            if (hp_neg_q) begin
              dot_now = 1'b0;
            end else if (hp_q == '0) begin
              dot_now = 1'b1;
            end else begin
              resync_d = 1'b0;
              if (blink_sum[BlinkW-1:0] >= hp_ext) begin
                dot_now = !dot_on_q;
                blink_d = '0;
              end else begin
                blink_d = blink_sum[BlinkW-1:0];
              end
            end
            dot_on_d = dot_now;
            gate_d   = (g == gate_t'(GateCount - 1)) ? '0 : g + gate_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    word_d = {WordW{1'b0}};
    word_d[GlyphW +: GlyphW] = glyph(map_sel_q, upper_q[g]);
    word_d[0 +: GlyphW]      = glyph(map_sel_q, lower_q[g]);
    word_d[GateBitBase + g]  = 1'b1;
    if (dot_now && g == gate_t'(1)) word_d[DotLowerBit] = 1'b1;
    if (dot_now && g == gate_t'(2)) word_d[DotUpperBit] = 1'b1;
    out_valid_d = accept ? emit : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_neg_q    <= 1'b0;
      hp_q        <= '0;
      blink_q     <= '0;
      dot_on_q    <= 1'b1;
      gate_q      <= '0;
      resync_q    <= 1'b0;
      stop_q      <= 1'b0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hp_neg_q    <= hp_neg_d;
      hp_q        <= hp_d;
      blink_q     <= blink_d;
      dot_on_q    <= dot_on_d;
      gate_q      <= gate_d;
      resync_q    <= resync_d;
      stop_q      <= stop_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      upper_q[0] <= digit0_i;
      upper_q[1] <= digit1_i;
      upper_q[2] <= digit2_i;
      lower_q[0] <= digit3_i;
      lower_q[1] <= digit4_i;
      lower_q[2] <= digit5_i;
    end
    if (accept && emit) begin
      word_q <= word_d;
      gidx_q <= g;
    end
  end

endmodule

// File: rtl/vfdmr_checker.sv
// port-level checks for the display multiplexer, bound to the top level
// depends on vfdmr_pkg and vfd_mux_refresh_with_dot_blink
`timescale 1ns / 1ps

module vfdmr_checker
  import vfdmr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [OpW-1:0]    op_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [WordW-1:0]  driver_word_o,
  input logic [GateW-1:0]  gate_index_o
);

  // a stalled word stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(driver_word_o))
    else $error("stalled output word changed");

  // gate bit agrees with gate index
  a_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(driver_word_o[WordW-1:GateBitBase]) &&
      ((gate_index_o == 2'd0 && driver_word_o[GateBitBase]) ||
       (gate_index_o == 2'd1 && driver_word_o[GateBitBase + 1]) ||
       (gate_index_o == 2'd2 && driver_word_o[GateBitBase + 2])))
    else $error("gate bit does not match gate index");

  // dots only on their gates
  a_dots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (gate_index_o == 2'd1 || !driver_word_o[DotLowerBit]) &&
      (gate_index_o == 2'd2 || !driver_word_o[DotUpperBit]))
    else $error("dot bit on the wrong gate");

  // a new word follows an accepted tick
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && op_i == OP_TICK))
    else $error("output word without accepted tick");

  // the gate wraps from 2 to 0 across consecutive words
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && gate_index_o == 2'd2 ##1 out_valid_o
      |-> gate_index_o == 2'd0)
    else $error("gate 2 not followed by gate 0");

endmodule

bind vfd_mux_refresh_with_dot_blink vfdmr_checker u_vfdmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .driver_word_o (driver_word_o),
  .gate_index_o  (gate_index_o)
);

// File: bench/vfdmr_drive_checker.sv
// driver word checker: follows the config and input channels, predicts each word
// and compares it with the output channel; depends on vfdmr_pkg
`timescale 1ns / 1ps

module vfdmr_drive_checker
  import vfdmr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIndexW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [OpW-1:0]            op_i,
  input  logic [CodeW-1:0]          digit0_i,
  input  logic [CodeW-1:0]          digit1_i,
  input  logic [CodeW-1:0]          digit2_i,
  input  logic [CodeW-1:0]          digit3_i,
  input  logic [CodeW-1:0]          digit4_i,
  input  logic [CodeW-1:0]          digit5_i,
  input  logic signed [PeriodW-1:0] blink_period_ms_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [WordW-1:0]          driver_word_i,
  input  logic [GateW-1:0]          gate_index_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [WordW-1:0] word;
    gate_t            gate;
  } drive_t;

  drive_t words_due[$];
  drive_t head;
  drive_t fresh;

  logic                map_sel;
  logic [RefreshW-1:0] refresh_ms;
  logic [CodeW-1:0]    codes [DigitCount];
  int                  half_period;
  logic [BlinkW-1:0]   blink_cnt;
  logic [BlinkW:0]     blink_sum;
  logic                dots_lit;
  int                  gate_now;
  logic                resync_due;
  logic                stop_due;
  logic                refreshing;
  int                  fails;

  function automatic logic [GlyphW-1:0] segments_of(input logic [CodeW-1:0] code);
    return map_sel ? GLYPH_MAP_B[code] : GLYPH_MAP_A[code];
  endfunction

  task automatic advance_display();
    case (op_e'(op_i))
      OP_UPDATE: begin
        codes[0] = digit0_i;
        codes[1] = digit1_i;
        codes[2] = digit2_i;
        codes[3] = digit3_i;
        codes[4] = digit4_i;
        codes[5] = digit5_i;
        if (blink_period_ms_i[PeriodW-1]) half_period = -1;
        else half_period = int'(blink_period_ms_i[PeriodW-2:1]);
        resync_due = 1'b1;
        refreshing = 1'b1;
      end
      OP_STOP: begin
        stop_due   = 1'b1;
        refreshing = 1'b0;
      end
      OP_TICK: begin
        if (stop_due) begin
          stop_due   = 1'b0;
          refreshing = 1'b0;
        end else if (refreshing) begin
          if (half_period > 0) begin
            if (resync_due) begin
              resync_due = 1'b0;
              blink_cnt  = half_period[BlinkW-1:0];
            end
            blink_sum = blink_cnt + refresh_ms;
            blink_cnt = blink_sum[BlinkW-1:0];
            if (int'(blink_cnt) >= half_period) begin
              dots_lit  = !dots_lit;
              blink_cnt = '0;
            end
          end else if (half_period < 0) begin
            dots_lit = 1'b0;
          end else begin
            dots_lit = 1'b1;
          end
          fresh = '0;
          fresh.word[15:8] = segments_of(codes[gate_now]);
          fresh.word[7:0]  = segments_of(codes[gate_now + 3]);
          fresh.word[GateBitBase + gate_now] = 1'b1;
          if (dots_lit && gate_now == 1) fresh.word[DotLowerBit] = 1'b1;
          if (dots_lit && gate_now == 2) fresh.word[DotUpperBit] = 1'b1;
          fresh.gate = gate_t'(gate_now);
          words_due.push_back(fresh);
          gate_now = (gate_now == 2) ? 0 : gate_now + 1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel      = 1'b0;
      refresh_ms   = RefreshReset;
      half_period  = 0;
      blink_cnt    = '0;
      dots_lit     = 1'b1;
      gate_now     = 0;
      resync_due   = 1'b0;
      stop_due     = 1'b0;
      refreshing   = 1'b0;
      fails        = 0;
      words_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (words_due.size() == 0) begin
          $error("driver word %h with none due", driver_word_i);
          fails++;
        end else begin
          head = words_due.pop_front();
          if (driver_word_i !== head.word) begin
            $error("driver_word expected %h actual %h", head.word, driver_word_i);
            fails++;
          end
          if (gate_index_i !== head.gate) begin
            $error("gate_index expected %0d actual %0d", head.gate, gate_index_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_MAP_SELECT: map_sel = cfg_data_i[0];
          CFG_REFRESH_MS: refresh_ms = cfg_data_i[RefreshW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) advance_display();
      fail_count_o <= fails;
      pending_o    <= words_due.size();
    end
  end

endmodule

// File: bench/vfd_mux_refresh_with_dot_blink_test.sv
// top of the display multiplexer bench: clock, reset, register phases, word traffic
// depends on vfdmr_pkg, vfdmr_drive_checker and the block itself
`timescale 1ns / 1ps

module vfd_mux_refresh_with_dot_blink_test;
  import vfdmr_pkg::*;

  localparam int WordsPerPhase = 210;
  localparam int IdleLimit     = 3000;
  localparam int SettleCycles  = 4;
  localparam int PressureAfter = 150;
  localparam int PressureHold  = 400;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIndexW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]       cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [OpW-1:0]            op_i;
  logic [CodeW-1:0]          digit0_i;
  logic [CodeW-1:0]          digit1_i;
  logic [CodeW-1:0]          digit2_i;
  logic [CodeW-1:0]          digit3_i;
  logic [CodeW-1:0]          digit4_i;
  logic [CodeW-1:0]          digit5_i;
  logic signed [PeriodW-1:0] blink_period_ms_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [WordW-1:0]          driver_word_o;
  logic [GateW-1:0]          gate_index_o;

  int fail_count;
  int words_pending;
  int idle_cycles;
  bit no_gaps;

  vfd_mux_refresh_with_dot_blink dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .digit0_i          (digit0_i),
    .digit1_i          (digit1_i),
    .digit2_i          (digit2_i),
    .digit3_i          (digit3_i),
    .digit4_i          (digit4_i),
    .digit5_i          (digit5_i),
    .blink_period_ms_i (blink_period_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .driver_word_o     (driver_word_o),
    .gate_index_o      (gate_index_o)
  );

  vfdmr_drive_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .op_i              (op_i),
    .digit0_i          (digit0_i),
    .digit1_i          (digit1_i),
    .digit2_i          (digit2_i),
    .digit3_i          (digit3_i),
    .digit4_i          (digit4_i),
    .digit5_i          (digit5_i),
    .blink_period_ms_i (blink_period_ms_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .driver_word_i     (driver_word_o),
    .gate_index_i      (gate_index_o),
    .fail_count_o      (fail_count),
    .pending_o         (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, free stretches, and one long hold-off to back up the input
  initial begin
    int  hold;
    int  taken;
    int  pick;
    bit  pressured;
    hold        = 0;
    taken       = 0;
    pressured   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) taken++;
      if (hold > 0) begin
        hold--;
      end else if (!pressured && taken >= PressureAfter) begin
        pressured = 1'b1;
        out_stall_i <= 1'b1;
        hold = PressureHold;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(0, 30);
        end else if (pick < 85) begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(0, 2);
        end else if (pick < 95) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(50, 150);
        end else begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // codes[4:0] is digit0, codes[29:25] is digit5
  task automatic put_word(input op_e op, input logic [6*CodeW-1:0] codes,
                          input logic signed [PeriodW-1:0] period);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= op;
    digit0_i          <= codes[0*CodeW +: CodeW];
    digit1_i          <= codes[1*CodeW +: CodeW];
    digit2_i          <= codes[2*CodeW +: CodeW];
    digit3_i          <= codes[3*CodeW +: CodeW];
    digit4_i          <= codes[4*CodeW +: CodeW];
    digit5_i          <= codes[5*CodeW +: CodeW];
    blink_period_ms_i <= period;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [6*CodeW-1:0] any_codes();
    logic [31:0] raw;
    raw = $urandom;
    return raw[6*CodeW-1:0];
  endfunction

  function automatic logic signed [PeriodW-1:0] any_period();
    case ($urandom_range(0, 7))
      0: return -17'sd1;
      1: return 17'sd0;
      2: return PeriodW'($urandom);
      3: return 17'sd65535;
      default: return PeriodW'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_phase(input logic map_sel, input logic [CfgDataW-1:0] refresh_ms);
    write_reg(CFG_MAP_SELECT, {7'd0, map_sel});
    write_reg(CFG_REFRESH_MS, refresh_ms);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // update, then a run of ticks with the odd stop and some unused op codes
  task automatic run_traffic(input int words);
    int sent;
    int pick;
    sent = 0;
    while (sent < words) begin
      no_gaps = ($urandom_range(0, 9) < 3);
      put_word(OP_UPDATE, any_codes(), any_period());
      sent++;
      repeat ($urandom_range(1, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          put_word(OP_NONE, any_codes(), any_period());
        end else if (pick < 6) begin
          put_word(OP_STOP, any_codes(), any_period());
          sent++;
        end else begin
          put_word(OP_TICK, any_codes(), any_period());
          sent++;
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    op_i              = OP_TICK;
    digit0_i          = '0;
    digit1_i          = '0;
    digit2_i          = '0;
    digit3_i          = '0;
    digit4_i          = '0;
    digit5_i          = '0;
    blink_period_ms_i = '0;
    no_gaps           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_phase(1'b0, 8'd1);
    put_word(OP_TICK, '0, 17'sd0);
    put_word(OP_NONE, '1, -17'sd1);
    put_word(OP_UPDATE, {5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd31}, -17'sd1);
    repeat (3) put_word(OP_TICK, '0, 17'sd0);
    put_word(OP_UPDATE, {5'd31, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0}, 17'sd0);
    repeat (3) put_word(OP_TICK, '1, -17'sd1);
    put_word(OP_UPDATE, any_codes(), 17'sd4);
    repeat (3) put_word(OP_TICK, '0, 17'sd0);
    put_word(OP_STOP, '0, 17'sd0);
    repeat (2) put_word(OP_TICK, '0, 17'sd0);
    put_word(OP_STOP, '0, 17'sd0);
    put_word(OP_UPDATE, any_codes(), 17'sd65535);
    repeat (2) put_word(OP_TICK, '0, 17'sd0);
    put_word(OP_UPDATE, any_codes(), 17'sh10000);
    put_word(OP_TICK, '0, 17'sd0);
    settle();

    set_phase(1'b1, 8'd255);
    run_traffic(WordsPerPhase);
    settle();
    set_phase(1'b0, 8'd0);
    run_traffic(WordsPerPhase);
    settle();
    set_phase(1'b1, 8'd5);
    run_traffic(WordsPerPhase);
    settle();
    set_phase(1'b0, 8'd200);
    run_traffic(WordsPerPhase);
    settle();
    set_phase(1'b1, 8'd1);
    run_traffic(WordsPerPhase);
    settle();
    set_phase(1'b0, 8'd37);
    run_traffic(WordsPerPhase);
    settle();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
